/* sv/phm_pkg.sv */
`timescale 1ns / 1ps
package phm_pkg;

    localparam int MAX_VERTICES_DEF = 1024;

    localparam int PW  = 21;          // point coordinate, Q12.8
    localparam int VW  = 22;          // vector / difference, Q13.8
    localparam int MW  = 2 * VW;      // product
    localparam int AW  = MW + 1;      // accumulated sum of two products
    localparam int QW  = 16;          // fraction bits
    localparam int FW  = QW + 1;      // fraction field incl. 1.0

    localparam logic [FW-1:0] FRAC_ONE = FW'(1) << QW;

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_LOAD     = 2'd1,
        OP_CONTAINS = 2'd2,
        OP_COLLIDE  = 2'd3
    } t_opcode;

    typedef struct packed {
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic                 mark;
    } t_vertex;

    typedef struct packed {
        logic          start;
        logic [AW-2:0] num;
        logic [AW-2:0] den;
    } t_div_req;

endpackage

/* sv/phm_in_if.sv */
`timescale 1ns / 1ps
interface phm_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    opcode;
    logic signed [phm_pkg::PW-1:0] point_x;
    logic signed [phm_pkg::PW-1:0] point_y;
    logic signed [phm_pkg::VW-1:0] vector_x;
    logic signed [phm_pkg::VW-1:0] vector_y;
    logic                          closes_outline;

    modport source (output valid, opcode, point_x, point_y, vector_x, vector_y,
                    closes_outline, input ready);
    modport sink   (input valid, opcode, point_x, point_y, vector_x, vector_y,
                    closes_outline, output ready);
endinterface

/* sv/phm_out_if.sv */
`timescale 1ns / 1ps
interface phm_out_if;
    logic                      valid;
    logic                      ready;
    logic                      inside_res;
    logic [phm_pkg::FW-1:0]    hit_fraction;
    logic                      overflow;

    modport source (output valid, inside_res, hit_fraction, overflow, input ready);
    modport sink   (input valid, inside_res, hit_fraction, overflow, output ready);
endinterface

/* sv/polygon_mask_hit_test.sv */
`timescale 1ns / 1ps
// Polygon mask hit test. Vertices are loaded one word at a time (load opcode) into a
// vertex store; closes_outline marks the last vertex of an outline, and only closed
// outlines take part in queries. A contains query casts a ray toward increasing y and
// reports odd crossing parity; a collide query reports 0 if the start is inside, else
// the smallest Q1.16 entry fraction (65536 = no hit). Clear and load give no word.
// A query walks every closed edge through one shared 22x22 registered multiplier: per
// edge it reads the vertex, forms the differences, takes six products and evaluates,
// and it runs the serial divider when a collide candidate is found. The block is not
// ready while a query runs. Loads beyond MAX_VERTICES are dropped and set the sticky
// overflow flag.
module polygon_mask_hit_test #(
    parameter int MAX_VERTICES = phm_pkg::MAX_VERTICES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    phm_in_if.sink    i_in,
    phm_out_if.source o_out
);
    localparam int ADW = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int PW  = phm_pkg::PW;
    localparam int VW  = phm_pkg::VW;
    localparam int AW  = phm_pkg::AW;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_FETCH = 9'b000000010,
        S_LOAD  = 9'b000000100,
        S_DIFF  = 9'b000001000,
        S_MUL   = 9'b000010000,
        S_EVAL  = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_NEXT  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state;

    // mask bookkeeping
    logic [CW-1:0]  r_vcnt;
    logic [CW-1:0]  r_closed;
    logic           r_ovf;

    // query word
    phm_pkg::t_opcode     r_op;
    logic signed [PW-1:0] r_px, r_py;
    logic signed [VW-1:0] r_vx, r_vy;

    // edge walk
    logic [ADW-1:0]       r_addr;
    logic                 r_first_pend;
    logic                 r_mark;
    logic                 r_closing;
    logic signed [PW-1:0] r_fx, r_fy;
    logic signed [PW-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [VW-1:0] r_dx, r_dy, r_wx, r_wy;
    logic [2:0]           r_k;
    logic signed [AW-1:0] r_s, r_cross, r_ub;
    logic                 r_par;
    logic [phm_pkg::FW-1:0] r_best;

    // output register
    logic                   r_ov;
    logic                   r_o_inside;
    logic [phm_pkg::FW-1:0] r_o_frac;
    logic                   r_o_ovf;

    logic                   w_in_acc;
    phm_pkg::t_opcode       w_in_op;
    phm_pkg::t_vertex       w_wr_data;
    phm_pkg::t_vertex       w_rd;
    logic                   w_wr_en;
    logic signed [VW-1:0]   w_ma, w_mb;
    logic signed [phm_pkg::MW-1:0] w_prod;
    logic signed [AW-1:0]   w_prod_x;
    phm_pkg::t_div_req      w_div_req;
    logic                   w_div_busy;
    logic [phm_pkg::QW-1:0] w_div_q;
    logic                   w_last;
    logic                   w_cross_hit;
    logic                   w_coll_hit;
    logic                   w_out_free;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_in_op    = phm_pkg::t_opcode'(i_in.opcode);
    assign w_out_free = !r_ov || o_out.ready;

    assign w_wr_en        = w_in_acc && (w_in_op == phm_pkg::OP_LOAD)
                            && (r_vcnt != CW'(MAX_VERTICES));
    assign w_wr_data.x    = i_in.point_x;
    assign w_wr_data.y    = i_in.point_y;
    assign w_wr_data.mark = i_in.closes_outline;

    phm_store #(.DEPTH(MAX_VERTICES), .ADW(ADW)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_vcnt[ADW-1:0]),
        .i_wr_data (w_wr_data),
        .i_rd_en   (r_state == S_FETCH),
        .i_rd_addr (r_addr),
        .o_rd_data (w_rd)
    );

    // operand schedule; wy*dx - dy*wx is both the ray test sum and ua
    always_comb begin
        unique case (r_k)
            3'd0:    begin w_ma = r_wy; w_mb = r_dx; end
            3'd1:    begin w_ma = r_dy; w_mb = r_wx; end
            3'd2:    begin w_ma = r_dx; w_mb = r_vy; end
            3'd3:    begin w_ma = r_dy; w_mb = r_vx; end
            3'd4:    begin w_ma = r_vx; w_mb = r_wy; end
            3'd5:    begin w_ma = r_vy; w_mb = r_wx; end
            default: begin w_ma = r_vy; w_mb = r_wx; end
        endcase
    end

    phm_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    assign w_prod_x = {w_prod[phm_pkg::MW-1], w_prod};

    // ray test: edge spans px (start closed, end open) and crossing y is not less than py
    assign w_cross_hit = (r_dx != '0) && ((r_ax <= r_px) == (r_px < r_bx))
                         && ((!r_dx[VW-1] && !r_s[AW-1])
                             || (r_dx[VW-1] && (r_s[AW-1] || (r_s == '0))));

    // entering edge with 0 <= ub < cross and 0 <= ua < cross needs a division
    assign w_coll_hit = (r_op == phm_pkg::OP_COLLIDE)
                        && !r_cross[AW-1] && (r_cross != '0)
                        && !r_ub[AW-1] && (r_ub < r_cross)
                        && !r_s[AW-1] && (r_s < r_cross);

    assign w_div_req.start = (r_state == S_EVAL) && w_coll_hit;
    assign w_div_req.num   = r_s[AW-2:0];
    assign w_div_req.den   = r_cross[AW-2:0];

    phm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_busy  (w_div_busy),
        .o_q     (w_div_q)
    );

    assign w_last = ((CW'(r_addr) + CW'(1)) == r_closed);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vcnt   <= '0;
            r_closed <= '0;
            r_ovf    <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            // S_DONE loads the next word itself
            if (r_ov && o_out.ready && (r_state != S_DONE)) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_op <= w_in_op;
                        r_px <= i_in.point_x;
                        r_py <= i_in.point_y;
                        r_vx <= i_in.vector_x;
                        r_vy <= i_in.vector_y;
                        unique case (w_in_op)
                            phm_pkg::OP_CLEAR: begin
                                r_vcnt   <= '0;
                                r_closed <= '0;
                                r_ovf    <= 1'b0;
                            end
                            phm_pkg::OP_LOAD: begin
                                if (r_vcnt == CW'(MAX_VERTICES)) begin
                                    r_ovf <= 1'b1;
                                end else begin
                                    r_vcnt <= r_vcnt + CW'(1);
                                    if (i_in.closes_outline) begin
                                        r_closed <= r_vcnt + CW'(1);
                                    end
                                end
                            end
                            phm_pkg::OP_CONTAINS, phm_pkg::OP_COLLIDE: begin
                                r_par        <= 1'b0;
                                r_best       <= phm_pkg::FRAC_ONE;
                                r_addr       <= '0;
                                r_first_pend <= 1'b1;
                                r_state      <= (r_closed == '0) ? S_DONE : S_FETCH;
                            end
                        endcase
                    end
                end
                S_FETCH: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_mark    <= w_rd.mark;
                    r_closing <= 1'b0;
                    r_ax      <= r_bx;
                    r_ay      <= r_by;
                    r_bx      <= w_rd.x;
                    r_by      <= w_rd.y;
                    if (r_first_pend) begin
                        // first vertex of an outline: no edge yet
                        r_fx <= w_rd.x;
                        r_fy <= w_rd.y;
                        if (w_rd.mark) begin
                            // single vertex outline, its edge is degenerate
                            if (w_last) begin
                                r_state <= S_DONE;
                            end else begin
                                r_addr  <= r_addr + ADW'(1);
                                r_state <= S_FETCH;
                            end
                        end else begin
                            r_first_pend <= 1'b0;
                            r_addr       <= r_addr + ADW'(1);
                            r_state      <= S_FETCH;
                        end
                    end else begin
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_dx    <= VW'(r_bx) - VW'(r_ax);
                    r_dy    <= VW'(r_by) - VW'(r_ay);
                    r_wx    <= VW'(r_ax) - VW'(r_px);
                    r_wy    <= VW'(r_ay) - VW'(r_py);
                    r_k     <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_k <= r_k + 3'd1;
                    unique case (r_k)
                        3'd1:    r_s     <= w_prod_x;
                        3'd2:    r_s     <= r_s - w_prod_x;
                        3'd3:    r_cross <= w_prod_x;
                        3'd4:    r_cross <= r_cross - w_prod_x;
                        3'd5:    r_ub    <= w_prod_x;
                        3'd6:    r_ub    <= r_ub - w_prod_x;
                        default: ;
                    endcase
                    if (r_k == 3'd6) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (w_cross_hit) begin
                        r_par <= !r_par;
                    end
                    r_state <= w_coll_hit ? S_DIV : S_NEXT;
                end
                S_DIV: begin
                    if (!w_div_busy) begin
                        if ({1'b0, w_div_q} < r_best) begin
                            r_best <= {1'b0, w_div_q};
                        end
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_mark && !r_closing) begin
                        // closing edge back to the outline's first vertex
                        r_closing <= 1'b1;
                        r_ax      <= r_bx;
                        r_ay      <= r_by;
                        r_bx      <= r_fx;
                        r_by      <= r_fy;
                        r_state   <= S_DIFF;
                    end else begin
                        // restore end vertex as the next edge's start
                        if (r_closing) begin
                            r_bx <= r_ax;
                            r_by <= r_ay;
                        end
                        r_first_pend <= r_mark;
                        if (w_last) begin
                            r_state <= S_DONE;
                        end else begin
                            r_addr  <= r_addr + ADW'(1);
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_ov       <= 1'b1;
                        r_o_inside <= r_par;
                        r_o_frac   <= (r_op == phm_pkg::OP_COLLIDE && !r_par) ? r_best : '0;
                        r_o_ovf    <= r_ovf;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.inside_res   = r_o_inside;
    assign o_out.hit_fraction = r_o_frac;
    assign o_out.overflow     = r_o_ovf;
endmodule

/* sv/phm_store.sv */
`timescale 1ns / 1ps
module phm_store #(
    parameter int DEPTH = phm_pkg::MAX_VERTICES_DEF,
    parameter int ADW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [ADW-1:0]   i_wr_addr,
    input  phm_pkg::t_vertex i_wr_data,
    input  logic             i_rd_en,
    input  logic [ADW-1:0]   i_rd_addr,
    output phm_pkg::t_vertex o_rd_data
);
    phm_pkg::t_vertex r_mem [DEPTH];
    phm_pkg::t_vertex r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;
endmodule

/* sv/phm_mul.sv */
`timescale 1ns / 1ps
module phm_mul (
    input  logic                          i_clk,
    input  logic signed [phm_pkg::VW-1:0] i_a,
    input  logic signed [phm_pkg::VW-1:0] i_b,
    output logic signed [phm_pkg::MW-1:0] o_p
);
    logic signed [phm_pkg::MW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

/* sv/phm_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. Expects num < den.
module phm_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  phm_pkg::t_div_req       i_req,
    output logic                    o_busy,
    output logic [phm_pkg::QW-1:0]  o_q
);
    localparam int DW = phm_pkg::AW - 1;
    localparam int CNW = $clog2(phm_pkg::QW + 1);

    logic [DW-1:0]           r_rem;
    logic [DW-1:0]           r_den;
    logic [phm_pkg::QW-1:0]  r_q;
    logic [CNW-1:0]          r_cnt;
    logic [DW:0]             w_rem2;
    logic                    w_ge;

    assign w_rem2 = {r_rem, 1'b0};
    assign w_ge   = w_rem2 >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_rem <= i_req.num;
            r_den <= i_req.den;
            r_q   <= '0;
            r_cnt <= CNW'(phm_pkg::QW);
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? DW'(w_rem2 - {1'b0, r_den}) : DW'(w_rem2);
            r_q   <= {r_q[phm_pkg::QW-2:0], w_ge};
            r_cnt <= r_cnt - CNW'(1);
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_q    = r_q;
endmodule

/* sv/phm_checker.sv */
`timescale 1ns / 1ps
module phm_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic [1:0]             in_opcode,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic                   out_inside,
    input logic [phm_pkg::FW-1:0] out_frac
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> $stable(out_frac))
        else $error("stalled fraction changed");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_frac <= phm_pkg::FRAC_ONE)
        else $error("fraction above one");

    a_inside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_inside |-> out_frac == '0)
        else $error("inside start with nonzero fraction");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && (in_opcode == phm_pkg::OP_CONTAINS
                                 || in_opcode == phm_pkg::OP_COLLIDE)
        |=> !in_ready)
        else $error("ready during query");
endmodule

bind polygon_mask_hit_test phm_checker u_phm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .in_valid   (i_in.valid),
    .in_ready   (i_in.ready),
    .in_opcode  (i_in.opcode),
    .out_valid  (o_out.valid),
    .out_ready  (o_out.ready),
    .out_inside (o_out.inside_res),
    .out_frac   (o_out.hit_fraction)
);

/* dv/polygon_mask_hit_test_checker.sv */
`timescale 1ns / 1ps
module polygon_mask_hit_test_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    phm_in_if    i_in,
    phm_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);
    localparam int DEPTH = phm_pkg::MAX_VERTICES_DEF;

    typedef struct {
        logic                   in_mask;
        logic [phm_pkg::FW-1:0] frac;
        logic                   ovf;
    } t_answer;

    // Mirror of the mask store.
    logic signed [phm_pkg::PW-1:0] mask_x[DEPTH];
    logic signed [phm_pkg::PW-1:0] mask_y[DEPTH];
    logic                          mask_mark[DEPTH];
    int unsigned                   stored_cnt;
    int unsigned                   closed_cnt;
    logic                          ovf_flag;

    t_answer answers_q[$];

    // Ray toward increasing y, edges closed at start x and open at end x.
    function automatic logic ray_parity(longint px, longint py);
        int unsigned s, e, p, hits;
        longint x0, y0, x1, y1, dx, sv;
        hits = 0;
        s = 0;
        while (s < closed_cnt) begin
            e = s;
            while (e + 1 < closed_cnt && !mask_mark[e]) e++;
            for (int unsigned i = s; i <= e; i++) begin
                p  = (i == s) ? e : i - 1;
                x0 = mask_x[p]; y0 = mask_y[p];
                x1 = mask_x[i]; y1 = mask_y[i];
                dx = x1 - x0;
                if (dx == 0) continue;
                if ((x0 <= px) != (px < x1)) continue;
                sv = (y0 - py) * dx + (y1 - y0) * (px - x0);
                if ((dx > 0 && sv >= 0) || (dx < 0 && sv <= 0)) hits++;
            end
            s = e + 1;
        end
        return hits[0];
    endfunction

    // Smallest entering fraction along the segment, Q1.16.
    function automatic logic [phm_pkg::FW-1:0] entry_fraction(longint sx, longint sy,
                                                              longint vx, longint vy);
        int unsigned s, e, p;
        longint ax, ay, bx, by, cr, wx, wy, ub, ua, f, best;
        best = 65536;
        s = 0;
        while (s < closed_cnt) begin
            e = s;
            while (e + 1 < closed_cnt && !mask_mark[e]) e++;
            for (int unsigned i = s; i <= e; i++) begin
                p  = (i == s) ? e : i - 1;
                ax = mask_x[p]; ay = mask_y[p];
                bx = longint'(mask_x[i]) - ax;
                by = longint'(mask_y[i]) - ay;
                cr = bx * vy - by * vx;
                if (cr <= 0) continue;
                wx = ax - sx; wy = ay - sy;
                ub = vx * wy - vy * wx;
                ua = bx * wy - by * wx;
                if (ub < 0 || ub >= cr || ua < 0) continue;
                f = (ua >= cr) ? 65536 : (ua <<< 16) / cr;
                if (f < best) best = f;
            end
            s = e + 1;
        end
        return best[phm_pkg::FW-1:0];
    endfunction

    task automatic take_word();
        t_answer a;
        case (phm_pkg::t_opcode'(i_in.opcode))
            phm_pkg::OP_CLEAR: begin
                stored_cnt = 0;
                closed_cnt = 0;
                ovf_flag   = 1'b0;
            end
            phm_pkg::OP_LOAD: begin
                if (stored_cnt >= DEPTH) begin
                    ovf_flag = 1'b1;
                end else begin
                    mask_x[stored_cnt]    = i_in.point_x;
                    mask_y[stored_cnt]    = i_in.point_y;
                    mask_mark[stored_cnt] = i_in.closes_outline;
                    stored_cnt++;
                    if (i_in.closes_outline) closed_cnt = stored_cnt;
                end
            end
            default: begin
                a.in_mask = ray_parity(i_in.point_x, i_in.point_y);
                a.frac    = '0;
                if (i_in.opcode == phm_pkg::OP_COLLIDE && !a.in_mask)
                    a.frac = entry_fraction(i_in.point_x, i_in.point_y,
                                            i_in.vector_x, i_in.vector_y);
                a.ovf = ovf_flag;
                answers_q = {answers_q, a};
            end
        endcase
    endtask

    task automatic check_word();
        t_answer a;
        if (answers_q.size() == 0) begin
            $display("%0t: unexpected word inside=%0d frac=%0d ovf=%0d", $time,
                     i_out.inside_res, i_out.hit_fraction, i_out.overflow);
            o_fail_count++;
            return;
        end
        a = answers_q.pop_front();
        if (i_out.inside_res !== a.in_mask) begin
            $display("%0t: inside_res expected %0d actual %0d", $time,
                     a.in_mask, i_out.inside_res);
            o_fail_count++;
        end
        if (i_out.hit_fraction !== a.frac) begin
            $display("%0t: hit_fraction expected %0d actual %0d", $time,
                     a.frac, i_out.hit_fraction);
            o_fail_count++;
        end
        if (i_out.overflow !== a.ovf) begin
            $display("%0t: overflow expected %0d actual %0d", $time,
                     a.ovf, i_out.overflow);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        stored_cnt   = 0;
        closed_cnt   = 0;
        ovf_flag     = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stored_cnt = 0;
            closed_cnt = 0;
            ovf_flag   = 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) take_word();
            if (i_out.valid && i_out.ready) check_word();
        end
        o_pending = answers_q.size();
    end

endmodule

/* dv/polygon_mask_hit_test_test.sv */
`timescale 1ns / 1ps
module polygon_mask_hit_test_test;

    logic i_clk = 1'b0;
    logic i_rst_n;

    phm_in_if  in_if();
    phm_out_if out_if();

    int fail_count;
    int pending;

    // Idle knobs, percent per cycle.
    int gap_pct   = 0;
    int stall_pct = 0;

    // Loads since the last clear; keeps query walks short.
    int loaded;

    polygon_mask_hit_test i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if.sink),
        .o_out  (out_if.source)
    );

    polygon_mask_hit_test_checker i_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .i_out       (out_if),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver stalls, one assignment per edge.
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Hard stop in case the block hangs.
    initial begin
        #100ms;
        $display("FAIL");
        $finish;
    end

    // Present one word and hold it until the handshake.
    // Valid stays high into the next word unless a gap is drawn.
    task automatic put_word(phm_pkg::t_opcode op, int px, int py, int vx, int vy, bit cl);
        if ($urandom_range(99) < gap_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < gap_pct) @(posedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.opcode         <= op;
        in_if.point_x        <= px[phm_pkg::PW-1:0];
        in_if.point_y        <= py[phm_pkg::PW-1:0];
        in_if.vector_x       <= vx[phm_pkg::VW-1:0];
        in_if.vector_y       <= vy[phm_pkg::VW-1:0];
        in_if.closes_outline <= cl;
        do @(posedge i_clk); while (!in_if.ready);
        if (op == phm_pkg::OP_CLEAR) loaded = 0;
        if (op == phm_pkg::OP_LOAD) loaded++;
    endtask

    // Sender holds off until every answer is back.
    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic int near(int span);
        return $urandom_range(2 * span) - span;
    endfunction

    task automatic random_polygon();
        int n, cx, cy, r;
        bit wild;
        n    = $urandom_range(6, 3);
        cx   = near(3000);
        cy   = near(3000);
        r    = $urandom_range(2000, 100);
        wild = ($urandom_range(9) == 0);
        for (int k = 0; k < n; k++) begin
            if (wild)
                put_word(phm_pkg::OP_LOAD, $urandom(), $urandom(), $urandom(), $urandom(),
                         k == n - 1);
            else
                put_word(phm_pkg::OP_LOAD, cx + near(r), cy + near(r), $urandom(),
                         $urandom(), (k == n - 1) && ($urandom_range(9) != 0));
        end
    endtask

    task automatic random_query();
        int px, py, vx, vy;
        phm_pkg::t_opcode op;
        op = $urandom_range(1) ? phm_pkg::OP_COLLIDE : phm_pkg::OP_CONTAINS;
        if ($urandom_range(6) == 0) begin
            px = $urandom(); py = $urandom();
        end else begin
            px = near(5000); py = near(5000);
        end
        if ($urandom_range(6) == 0) begin
            vx = $urandom(); vy = $urandom();
        end else begin
            vx = near(12000); vy = near(12000);
        end
        put_word(op, px, py, vx, vy, 1'($urandom_range(1)));
    endtask

    initial begin
        i_rst_n              = 1'b0;
        in_if.valid          = 1'b0;
        in_if.opcode         = phm_pkg::OP_CLEAR;
        in_if.point_x        = '0;
        in_if.point_y        = '0;
        in_if.vector_x       = '0;
        in_if.vector_y       = '0;
        in_if.closes_outline = 1'b0;
        out_if.ready         = 1'b0;
        loaded               = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty mask: not inside, no hit.
        put_word(phm_pkg::OP_CONTAINS, 0, 0, 0, 0, 0);
        put_word(phm_pkg::OP_COLLIDE, -100, 50, 4000, 0, 0);
        // Open outline is ignored.
        put_word(phm_pkg::OP_LOAD, 0, 0, 0, 0, 0);
        put_word(phm_pkg::OP_LOAD, 1000, 0, 0, 0, 0);
        put_word(phm_pkg::OP_LOAD, 1000, 1000, 0, 0, 0);
        put_word(phm_pkg::OP_CONTAINS, 500, 300, 0, 0, 0);
        // Closing vertex makes it a square with two vertical edges.
        put_word(phm_pkg::OP_LOAD, 0, 1000, 0, 0, 1);
        put_word(phm_pkg::OP_CONTAINS, 500, 500, 0, 0, 0);
        put_word(phm_pkg::OP_CONTAINS, 0, 500, 0, 0, 0);      // on the start-x boundary
        put_word(phm_pkg::OP_CONTAINS, 1000, 500, 0, 0, 0);   // on the open end boundary
        put_word(phm_pkg::OP_COLLIDE, -500, 500, 2000, 0, 0); // entry at one quarter
        put_word(phm_pkg::OP_COLLIDE, 500, 500, 3000, 0, 0);  // start inside
        put_word(phm_pkg::OP_COLLIDE, -500, 500, -2000, 7, 1);
        // Two-vertex outline cancels itself.
        put_word(phm_pkg::OP_LOAD, 200, 200, 0, 0, 0);
        put_word(phm_pkg::OP_LOAD, 800, -300, 0, 0, 1);
        put_word(phm_pkg::OP_CONTAINS, 500, 500, 0, 0, 0);
        // Field extremes.
        put_word(phm_pkg::OP_COLLIDE, -1048576, -1048576, 2097151, 2097151, 1);
        put_word(phm_pkg::OP_COLLIDE, 1048575, 1048575, -2097152, -2097152, 0);
        put_word(phm_pkg::OP_CONTAINS, 1048575, -1048576, -1, -1, 1);

        // Fresh mask after a clear, then clear again.
        drain();
        put_word(phm_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
        put_word(phm_pkg::OP_LOAD, -50, -50, 0, 0, 0);
        put_word(phm_pkg::OP_LOAD, 50, -50, 0, 0, 0);
        put_word(phm_pkg::OP_LOAD, 0, 80, 0, 0, 1);
        put_word(phm_pkg::OP_CONTAINS, 0, 0, 0, 0, 0);
        put_word(phm_pkg::OP_COLLIDE, -200, 0, 400, 0, 0);
        put_word(phm_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
        put_word(phm_pkg::OP_CONTAINS, 0, 0, 0, 0, 0);
        drain();

        // Random part in four idle phases.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 59; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 59; end
                default: begin gap_pct = 8; stall_pct = 8; end
            endcase
            for (int k = 0; k < 14; k++) begin
                if (loaded >= 24 || $urandom_range(99) < 4)
                    put_word(phm_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
                else if ($urandom_range(99) < 30)
                    random_polygon();
                else
                    random_query();
            end
            drain();
        end

        gap_pct   = 0;
        stall_pct = 0;
        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
sv/phm_pkg.sv
sv/phm_in_if.sv
sv/phm_out_if.sv
sv/phm_store.sv
sv/phm_mul.sv
sv/phm_div.sv
sv/polygon_mask_hit_test.sv
sv/phm_checker.sv
dv/polygon_mask_hit_test_checker.sv
dv/polygon_mask_hit_test_test.sv
